// ----- hdl/scfap_pkg.sv -----
// Shared types and constants for the signed configuration auth field parser.
// No dependencies; the step logic, the result register and the top level use this.
package scfap_pkg;

  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_KEYLEN  = 4'd1,
    PH_KEY     = 4'd2,
    PH_AUTHLEN = 4'd3,
    PH_AUTH    = 4'd4,
    PH_EXPIRY  = 4'd5,
    PH_ALG     = 4'd6,
    PH_SIGLEN  = 4'd7,
    PH_SIG     = 4'd8,
    PH_IGNORED = 4'd9
  } phase_t;

  localparam logic [15:0] EXPIRY_BYTES = 16'd8;
  localparam logic [15:0] WORD_BYTES   = 16'd2;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] remaining;
    logic [15:0] position;
    logic [7:0]  length_high;
    logic [7:0]  method_reg;
    logic [63:0] expiry_reg;
    logic [15:0] algorithm_reg;
    logic        signed_flag;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:         PH_METHOD,
    remaining:     16'd0,
    position:      16'd0,
    length_high:   8'd0,
    method_reg:    8'd0,
    expiry_reg:    64'd0,
    algorithm_reg: 16'd0,
    signed_flag:   1'b0
  };

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  section;
    logic [15:0] byte_index;
    logic        done_res;
    logic        status;
    logic [7:0]  method;
    logic        has_signature;
    logic [63:0] expiry;
    logic [15:0] algorithm;
  } result_t;

endpackage

// ----- hdl/scfap_step.sv -----
// Per-byte parse logic: next parser state and the result for one request.
// Depends on scfap_pkg.
module scfap_step
  import scfap_pkg::*;
(
  input  parse_state_t st,
  input  logic [7:0]   byte_in,
  input  logic         last,
  output parse_state_t st_next,
  output result_t      res
);

  // Two-byte big-endian length; enter the body, or skip it when empty.
  function automatic parse_state_t length_step(parse_state_t s, logic [7:0] b,
                                               phase_t body, phase_t after);
    parse_state_t n;
    logic [15:0]  len;
    n   = s;
    len = {s.length_high, b};
    if (s.position == 16'd0) begin
      n.length_high = b;
      n.position    = 16'd1;
    end else begin
      n.remaining = len;
      n.position  = 16'd0;
      n.phase     = (len == 16'd0) ? after : body;
    end
    return n;
  endfunction

  function automatic parse_state_t body_step(parse_state_t s, phase_t after);
    parse_state_t n;
    n           = s;
    n.remaining = s.remaining - 16'd1;
    n.position  = s.position + 16'd1;
    if (n.remaining == 16'd0) begin
      n.phase    = after;
      n.position = 16'd0;
    end
    return n;
  endfunction

  parse_state_t nxt;
  logic [15:0]  pos_inc;
  logic         ok;

  assign pos_inc = st.position + 16'd1;

  always_comb begin
    nxt = st;
    if (st.phase >= PH_AUTHLEN) begin
      nxt.signed_flag = 1'b1;
    end
    case (st.phase)
      PH_METHOD: begin
        nxt.method_reg = byte_in;
        nxt.phase      = PH_KEYLEN;
        nxt.position   = 16'd0;
      end
      PH_KEYLEN:  nxt = length_step(nxt, byte_in, PH_KEY, PH_AUTHLEN);
      PH_KEY:     nxt = body_step(nxt, PH_AUTHLEN);
      PH_AUTHLEN: nxt = length_step(nxt, byte_in, PH_AUTH, PH_EXPIRY);
      PH_AUTH:    nxt = body_step(nxt, PH_EXPIRY);
      PH_EXPIRY: begin
        nxt.expiry_reg = {st.expiry_reg[55:0], byte_in};
        nxt.position   = pos_inc;
        if (pos_inc == EXPIRY_BYTES) begin
          nxt.phase    = PH_ALG;
          nxt.position = 16'd0;
        end
      end
      PH_ALG: begin
        nxt.algorithm_reg = {st.algorithm_reg[7:0], byte_in};
        nxt.position      = pos_inc;
        if (pos_inc == WORD_BYTES) begin
          nxt.phase    = PH_SIGLEN;
          nxt.position = 16'd0;
        end
      end
      PH_SIGLEN:  nxt = length_step(nxt, byte_in, PH_SIG, PH_IGNORED);
      PH_SIG:     nxt = body_step(nxt, PH_IGNORED);
      default: begin
        // trailing bytes: count up, hold at the top
        nxt.phase = PH_IGNORED;
        if (st.position != POS_MAX) begin
          nxt.position = pos_inc;
        end
      end
    endcase
  end

  // ok: past the signature, or ended exactly after the keys
  assign ok = (nxt.phase == PH_IGNORED) ||
              (nxt.phase == PH_AUTHLEN && nxt.position == 16'd0 && !nxt.signed_flag);

  always_comb begin
    res.byte_out      = byte_in;
    res.section       = st.phase;
    res.byte_index    = st.position;
    res.done_res      = last;
    res.status        = last && !ok;
    res.method        = nxt.method_reg;
    res.has_signature = nxt.signed_flag;
    res.expiry        = (nxt.phase > PH_EXPIRY) ? nxt.expiry_reg : 64'd0;
    res.algorithm     = (nxt.phase > PH_ALG) ? nxt.algorithm_reg : 16'd0;
  end

  // drop all state after the final byte
  assign st_next = last ? STATE_RESET : nxt;

endmodule

// ----- hdl/scfap_out_reg.sv -----
// Result register with valid/stall handshake toward the consumer.
// Depends on scfap_pkg.
module scfap_out_reg
  import scfap_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t d,
  input  logic    res_stall,
  output logic    res_valid,
  output result_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

// ----- hdl/signed_config_auth_field_parser.sv -----
// Signed configuration auth field parser: tags each message byte by section.
// An accepted request's result is registered and shows on the outputs in the next cycle.
// Throughput: one byte per cycle while req_stall is low; the parser state updates
// as the byte is taken, and the result register frees as the consumer takes it.
// Reset (rst, synchronous): parser back to expecting a method byte, no result.
// Depends on scfap_pkg, scfap_step and scfap_out_reg.
module signed_config_auth_field_parser
  import scfap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [7:0]  byte_in,
  input  logic        last,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  byte_out,
  output logic [3:0]  section,
  output logic [15:0] byte_index,
  output logic        done_res,
  output logic        status,
  output logic [7:0]  method,
  output logic        has_signature,
  output logic [63:0] expiry,
  output logic [15:0] algorithm
);

  parse_state_t st;
  parse_state_t st_next;
  result_t      res_d;
  result_t      res_q;
  logic         accept;

  // hold requests only while a result waits and the consumer stalls
  assign req_stall = res_valid && res_stall;
  assign accept    = req_valid && !req_stall;

  scfap_step u_step (
    .st      (st),
    .byte_in (byte_in),
    .last    (last),
    .st_next (st_next),
    .res     (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  scfap_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .d         (res_d),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .q         (res_q)
  );

  assign byte_out      = res_q.byte_out;
  assign section       = res_q.section;
  assign byte_index    = res_q.byte_index;
  assign done_res      = res_q.done_res;
  assign status        = res_q.status;
  assign method        = res_q.method;
  assign has_signature = res_q.has_signature;
  assign expiry        = res_q.expiry;
  assign algorithm     = res_q.algorithm;

endmodule
